FILE: hdl/itoa_pkg.sv
`timescale 1ns / 1ps
package itoa_pkg;

	// default sizes
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_CHARS_DEF  = 33;
	localparam int QUEUE_DEPTH    = 2;

	// radix register
	localparam int              RADIX_W     = 6;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	// character codes
	localparam int           CHAR_W      = 8;
	localparam logic [7:0]   ASCII_MINUS = 8'h2D;
	localparam logic [7:0]   ASCII_ZERO  = 8'h30;
	localparam logic [7:0]   ASCII_NINE  = 8'h39;
	localparam logic [7:0]   ASCII_LOW_A = 8'h61;
	localparam logic [7:0]   ASCII_LOW_Z = 8'h7A;
	localparam logic [7:0]   ASCII_NUL   = 8'h00;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	// classified job handed from front to back
	typedef struct packed {
		logic               neg;
		logic               invalid;
		logic [RADIX_W-1:0] radix;
	} job_ctl_t;

	// back end sequencer
	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_SIGN,
		B_RD,
		B_LD,
		B_BAD
	} back_state_t;

	// digit value to lower-case ascii
	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < DEC_DIGITS) begin
			return ASCII_ZERO + dx;
		end else begin
			return ASCII_LOW_A + dx - {{(CHAR_W-RADIX_W){1'b0}}, DEC_DIGITS};
		end
	endfunction

endpackage

FILE: hdl/signed_integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// Signed integer to ASCII text in a programmable radix (2..36).
// Channels, all valid/ready, transfer when both are high:
//   radix   : write of the 6-bit radix register (reset 10); always ready.
//             Write it only while no conversion is pending.
//   value   : one signed integer per transfer; goes into a 2-entry queue.
//   res     : char_code/is_last/is_empty, most significant character first,
//             a leading '-' for negative values, is_last on the final one.
//             A radix outside 2..36 gives one item with is_empty set.
// Per item: the back end takes it from the queue, then divides once per
// digit (the shared bit-serial divider produces one quotient bit a cycle),
// writes a sign if the value is negative, and reads each character back
// from the character stack through the read and load states. The back end
// handles one number at a time; the queue takes up to two more meanwhile.
// Reset clears the queue, the sequencer and the output valid flag and sets
// the radix to 10. When the receiver stalls, the output holds and the back
// end waits before its next output; the front keeps accepting until the queue is full.
module signed_integer_to_ascii_radix #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
	parameter int MAX_CHARS  = itoa_pkg::MAX_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_valid,
	output logic                         radix_ready,
	input  logic [itoa_pkg::RADIX_W-1:0] radix,
	input  logic                         value_valid,
	output logic                         value_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [itoa_pkg::CHAR_W-1:0]  char_code,
	output logic                         is_last,
	output logic                         is_empty
);
	import itoa_pkg::*;

	localparam int JOB_W = VALUE_BITS + $bits(job_ctl_t);

	logic                  push_valid, push_ready, pop_valid, pop_ready;
	logic [VALUE_BITS-1:0] push_mag, pop_mag;
	job_ctl_t              push_ctl, pop_ctl;
	logic [JOB_W-1:0]      pop_data;

	// front: radix register and classification
	itoa_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix_valid(radix_valid),
		.radix_ready(radix_ready),
		.radix      (radix),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value      (value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_mag   (push_mag),
		.push_ctl   (push_ctl)
	);

	// job queue between the two halves
	itoa_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_ctl, push_mag}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign pop_mag = pop_data[VALUE_BITS-1:0];
	assign pop_ctl = job_ctl_t'(pop_data[JOB_W-1:VALUE_BITS]);

	// back: divider, character stack, output register
	itoa_back #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_CHARS (MAX_CHARS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(pop_valid),
		.job_ready(pop_ready),
		.job_mag  (pop_mag),
		.job_ctl  (pop_ctl),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.char_code(char_code),
		.is_last  (is_last),
		.is_empty (is_empty)
	);

	// an empty item is the whole run and carries no character
	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_empty |-> is_last && (char_code == ASCII_NUL))
		else $error("empty item not marked last or carries a character");

	// a real item is a sign, a decimal digit or a lower-case letter
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_empty |-> (char_code == ASCII_MINUS) ||
			((char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE)) ||
			((char_code >= ASCII_LOW_A) && (char_code <= ASCII_LOW_Z)))
		else $error("character outside the digit set");

	// the sign always leads, so it never closes a run
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (char_code == ASCII_MINUS) |-> !is_last && !is_empty)
		else $error("minus sign at the end of a run");

endmodule

FILE: hdl/itoa_front.sv
`timescale 1ns / 1ps
module itoa_front #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_valid,
	output logic                         radix_ready,
	input  logic [itoa_pkg::RADIX_W-1:0] radix,
	input  logic                         value_valid,
	output logic                         value_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [VALUE_BITS-1:0]        push_mag,
	output itoa_pkg::job_ctl_t           push_ctl
);
	import itoa_pkg::*;

	logic [RADIX_W-1:0]    radix_q;
	logic [VALUE_BITS-1:0] v_u;
	logic                  neg;

	// radix register, always writable
	assign radix_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_valid) begin
			radix_q <= radix;
		end
	end

	// classify: sign, magnitude, radix check
	assign v_u  = $unsigned(value);
	assign neg  = v_u[VALUE_BITS-1];

	always_comb begin
		push_mag         = neg ? (~v_u + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_u;
		push_ctl.neg     = neg;
		push_ctl.invalid = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
		push_ctl.radix   = radix_q;
	end

	// transfer straight into the queue
	assign push_valid  = value_valid;
	assign value_ready = push_ready;

endmodule

FILE: hdl/itoa_queue.sv
`timescale 1ns / 1ps
module itoa_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import itoa_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/itoa_back.sv
`timescale 1ns / 1ps
module itoa_back #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
	parameter int MAX_CHARS  = itoa_pkg::MAX_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  logic [VALUE_BITS-1:0]       job_mag,
	input  itoa_pkg::job_ctl_t          job_ctl,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [itoa_pkg::CHAR_W-1:0] char_code,
	output logic                        is_last,
	output logic                        is_empty
);
	import itoa_pkg::*;

	localparam int BIT_W = $clog2(VALUE_BITS);
	localparam int IDX_W = $clog2(MAX_CHARS);
	localparam int CNT_W = $clog2(MAX_CHARS + 1);

	back_state_t           state_q, state_d;
	logic [VALUE_BITS-1:0] quo_q, quo_nx;
	logic [RADIX_W-1:0]    rem_q;
	logic [RADIX_W:0]      trial, rem_nx;
	logic                  ge;
	logic [BIT_W-1:0]      bit_q;
	logic                  bit_last;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      ptr_q;
	logic                  neg_q;
	logic [RADIX_W-1:0]    radix_q;

	logic [CHAR_W-1:0]     stack [MAX_CHARS];
	logic [CHAR_W-1:0]     rdata_q;

	logic                  load_job, div_step, st_we, ptr_load, ptr_dec, out_load;
	logic [CHAR_W-1:0]     st_wdata;
	logic [CHAR_W-1:0]     out_char;
	logic                  out_last, out_empty, slot_free;

	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q, out_empty_q;

	// one restoring division step: one quotient bit per cycle
	assign trial    = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge       = (trial >= {1'b0, radix_q});
	assign rem_nx   = ge ? (trial - {1'b0, radix_q}) : trial;
	assign quo_nx   = {quo_q[VALUE_BITS-2:0], ge};
	assign bit_last = (bit_q == BIT_W'(VALUE_BITS - 1));

	assign slot_free = !out_valid_q || res_ready;

	// sequencer: divide, push digits and any sign, then read them back in reverse; an invalid radix gives one empty item
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		load_job  = 1'b0;
		div_step  = 1'b0;
		st_we     = 1'b0;
		st_wdata  = digit_glyph(rem_nx[RADIX_W-1:0]);
		ptr_load  = 1'b0;
		ptr_dec   = 1'b0;
		out_load  = 1'b0;
		out_char  = ASCII_NUL;
		out_last  = 1'b0;
		out_empty = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					load_job = 1'b1;
					state_d  = job_ctl.invalid ? B_BAD : B_DIV;
				end
			end
			B_DIV: begin
				div_step = 1'b1;
				if (bit_last) begin
					st_we = 1'b1;
					if (quo_nx == '0) begin
						if (neg_q) begin
							state_d = B_SIGN;
						end else begin
							ptr_load = 1'b1;
							state_d  = B_RD;
						end
					end
				end
			end
			B_SIGN: begin
				st_we    = 1'b1;
				st_wdata = ASCII_MINUS;
				ptr_load = 1'b1;
				state_d  = B_RD;
			end
			B_RD: begin
				state_d = B_LD;
			end
			B_LD: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_char = rdata_q;
					out_last = (ptr_q == '0);
					if (ptr_q == '0) begin
						state_d = B_IDLE;
					end else begin
						ptr_dec = 1'b1;
						state_d = B_RD;
					end
				end
			end
			B_BAD: begin
				if (slot_free) begin
					out_load  = 1'b1;
					out_last  = 1'b1;
					out_empty = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider and counters
	always_ff @(posedge clk) begin
		if (load_job) begin
			quo_q   <= job_mag;
			rem_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= job_ctl.neg;
			radix_q <= job_ctl.radix;
		end else if (div_step) begin
			quo_q <= quo_nx;
			if (bit_last) begin
				rem_q <= '0;
				bit_q <= '0;
			end else begin
				rem_q <= rem_nx[RADIX_W-1:0];
				bit_q <= bit_q + 1'b1;
			end
		end
		if (st_we) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (ptr_load) begin
			ptr_q <= cnt_q[IDX_W-1:0];
		end else if (ptr_dec) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	// character stack, one write and one registered read port
	always_ff @(posedge clk) begin
		if (st_we) begin
			stack[cnt_q[IDX_W-1:0]] <= st_wdata;
		end
		rdata_q <= stack[ptr_q];
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q  <= out_char;
			out_last_q  <= out_last;
			out_empty_q <= out_empty;
		end
	end

	assign res_valid = out_valid_q;
	assign char_code = out_char_q;
	assign is_last   = out_last_q;
	assign is_empty  = out_empty_q;

endmodule

FILE: tb/sv/tb_signed_integer_to_ascii_radix.sv
`timescale 1ns / 1ps
module tb_signed_integer_to_ascii_radix;
	import itoa_pkg::*;

	localparam int VALUE_W      = 32;
	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 40;
	localparam string DIGIT_CHARS = "0123456789abcdefghijklmnopqrstuvwxyz";

	// one expected character of a number's text
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
		logic              empty;
	} text_char_t;

	logic                      clk;
	logic                      arst_n;
	logic                      radix_valid;
	logic                      radix_ready;
	logic [RADIX_W-1:0]        radix;
	logic                      value_valid;
	logic                      value_ready;
	logic signed [VALUE_W-1:0] value;
	logic                      res_valid;
	logic                      res_ready;
	logic [CHAR_W-1:0]         char_code;
	logic                      is_last;
	logic                      is_empty;

	text_char_t         pending_chars[$];
	logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
	int                 sender_idle_pct = 0;
	int                 receiver_stall_pct = 0;
	bit                 long_hold_req = 1'b0;
	int                 error_count = 0;
	int                 items_sent = 0;
	int                 chars_checked = 0;
	int                 radix_writes = 0;
	int                 input_stall_cycles = 0;
	int                 quiet_cycles = 0;

	signed_integer_to_ascii_radix i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_valid (radix_valid),
		.radix_ready (radix_ready),
		.radix       (radix),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.char_code   (char_code),
		.is_last     (is_last),
		.is_empty    (is_empty)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// expected text of one number in the current radix
	function automatic void predict_text(input logic [VALUE_W-1:0] number);
		logic [VALUE_W-1:0] magnitude;
		logic [VALUE_W-1:0] base;
		logic [CHAR_W-1:0]  glyphs[$];
		base = {{(VALUE_W-RADIX_W){1'b0}}, radix_setting};
		if (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX) begin
			pending_chars.push_back('{code: ASCII_NUL, last: 1'b1, empty: 1'b1});
			return;
		end
		magnitude = number[VALUE_W-1] ? {VALUE_W{1'b0}} - number : number;
		do begin
			glyphs.push_front(DIGIT_CHARS[int'(magnitude % base)]);
			magnitude = magnitude / base;
		end while (magnitude != 0);
		if (number[VALUE_W-1])
			glyphs.push_front(ASCII_MINUS);
		foreach (glyphs[i])
			pending_chars.push_back('{code: glyphs[i], last: (i == glyphs.size() - 1),
				empty: 1'b0});
	endfunction

	// random number, weighted toward small magnitudes and the range ends
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return VALUE_W'($urandom_range(40));
			1: return {VALUE_W{1'b0}} - VALUE_W'($urandom_range(1, 40));
			2: return {1'b1, {(VALUE_W-1){1'b0}}} + VALUE_W'($urandom_range(3));
			3: return {1'b0, {(VALUE_W-1){1'b1}}} - VALUE_W'($urandom_range(3));
			default: return $urandom();
		endcase
	endfunction

	// mostly valid radix values, some outside 2..36
	function automatic logic [RADIX_W-1:0] pick_radix();
		if ($urandom_range(5) == 0)
			return $urandom_range(1) ? RADIX_W'($urandom_range(1)) :
				RADIX_W'($urandom_range(37, 63));
		return RADIX_W'($urandom_range(2, 36));
	endfunction

	// offer one number, with random idle cycles before it
	task automatic send_value(input logic [VALUE_W-1:0] number);
		if ($urandom_range(99) < sender_idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
		end
		value <= number;
		value_valid <= 1'b1;
		@(posedge clk);
		while (!value_ready) @(posedge clk);
		predict_text(number);
		items_sent++;
	endtask

	// stop offering and let every expected character arrive
	task automatic wait_idle();
		value_valid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// radix register write, only with the block idle
	task automatic write_radix(input logic [RADIX_W-1:0] new_radix);
		wait_idle();
		radix <= new_radix;
		radix_valid <= 1'b1;
		@(posedge clk);
		while (!radix_ready) @(posedge clk);
		radix_valid <= 1'b0;
		radix_setting = new_radix;
		radix_writes++;
	endtask

	// default radix after reset, ordinary and extreme values
	task automatic test_reset_radix();
		logic [VALUE_W-1:0] nums[8] = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10,
			-32'sd123456789, 32'h7fff_ffff, 32'h8000_0000};
		foreach (nums[i]) send_value(nums[i]);
	endtask

	// smallest and largest valid radix; radix 2 gives the longest text; then two values in radix 16
	task automatic test_radix_extremes();
		logic [VALUE_W-1:0] bin_nums[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0,
			32'hffff_ffff};
		logic [VALUE_W-1:0] b36_nums[5] = '{32'd35, 32'd36, 32'd1295, 32'h8000_0000,
			32'h7fff_ffff};
		write_radix(6'd2);
		foreach (bin_nums[i]) send_value(bin_nums[i]);
		write_radix(6'd36);
		foreach (b36_nums[i]) send_value(b36_nums[i]);
		write_radix(6'd16);
		send_value(32'hdead_beef);
		send_value(32'h0000_00ff);
	endtask

	// radix outside 2..36 gives one empty item
	task automatic test_invalid_radix();
		write_radix(6'd0);
		send_value(32'd5);
		write_radix(6'd1);
		send_value(32'hffff_fff9);
		write_radix(6'd37);
		send_value(32'd0);
		write_radix(6'd63);
		send_value(32'h8000_0000);
	endtask

	// long receiver hold while numbers keep coming, input must stall
	task automatic test_back_pressure();
		write_radix(6'd10);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		long_hold_req = 1'b1;
		repeat (10) send_value(pick_value());
		wait_idle();
	endtask

	// random numbers and radix values under each idling mix
	task automatic test_random_traffic();
		int idle_set[4]  = '{0, 68, 0, 23};
		int stall_set[4] = '{0, 0, 68, 23};
		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 3; s++) begin
				write_radix(pick_radix());
				sender_idle_pct = idle_set[p];
				receiver_stall_pct = stall_set[p];
				repeat (25) send_value(pick_value());
			end
		end
	endtask

	// receiver: random stalls plus an occasional long hold
	initial begin
		int hold_left;
		hold_left = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				res_ready <= 1'b0;
			end else if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else begin
				res_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// compare each character transfer with the oldest expectation
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && res_valid && res_ready) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, got code %h last %b empty %b",
					$time, char_code, is_last, is_empty);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code) begin
					$display("%0t: char_code expected %h got %h", $time, want.code, char_code);
					error_count++;
				end
				if (is_last !== want.last) begin
					$display("%0t: is_last expected %b got %b", $time, want.last, is_last);
					error_count++;
				end
				if (is_empty !== want.empty) begin
					$display("%0t: is_empty expected %b got %b", $time, want.empty, is_empty);
					error_count++;
				end
			end
		end
	end

	// input stall count and watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (value_valid && !value_ready)
			input_stall_cycles <= input_stall_cycles + 1;
		if ((value_valid && value_ready) || (res_valid && res_ready) ||
				(radix_valid && radix_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d characters outstanding",
				$time, quiet_cycles, pending_chars.size());
			$display("tb_signed_integer_to_ascii_radix: FAIL");
			$finish;
		end
	end

	// reset, then the tests in turn
	initial begin
		arst_n = 1'b0;
		radix_valid = 1'b0;
		radix = RADIX_RESET;
		value_valid = 1'b0;
		value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_radix_extremes();
		test_invalid_radix();
		test_back_pressure();
		test_random_traffic();
		wait_idle();
		$display("converted %0d numbers into %0d checked characters over %0d radix writes",
			items_sent, chars_checked, radix_writes);
		$display("radix 0..63 incl. invalid bases, idle/stall mixes, %0d input stall cycles",
			input_stall_cycles);
		if (error_count == 0 && pending_chars.size() == 0)
			$display("tb_signed_integer_to_ascii_radix: PASS");
		else
			$display("tb_signed_integer_to_ascii_radix: FAIL");
		$finish;
	end

endmodule
